// ----- rtl/core/rc6_pkg.sv -----
// Shared constants, types and rotate helpers for the RC6 block cipher.
package rc6_pkg;

  localparam int ROUNDS        = 20;
  localparam int TABLE_SIZE    = 2 * ROUNDS + 4;
  localparam int MAX_KEY_WORDS = 8;
  localparam int KEY_REGS      = 4;
  localparam int KEY_REG_WORDS = 2 * KEY_REGS;

  localparam int WORD_W     = 32;
  localparam int ROT_W      = 5;
  localparam int ADDR_W     = $clog2(TABLE_SIZE);
  localparam int ROUND_W    = $clog2(ROUNDS + 1);
  localparam int KIDX_W     = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int KCNT_W     = 4;
  localparam int KEY_CAP    = (MAX_KEY_WORDS < 15) ? MAX_KEY_WORDS : 15;
  localparam int MIX_MAX    = 3 * ((KEY_CAP > TABLE_SIZE) ? KEY_CAP : TABLE_SIZE);
  localparam int STEP_W     = $clog2(MIX_MAX);
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t MAGIC_P = 32'hB7E15163;
  localparam word_t MAGIC_Q = 32'h9E3779B9;

  localparam int RK_WHITE_B = 0;
  localparam int RK_WHITE_D = 1;
  localparam int RK_WHITE_A = 2 * ROUNDS + 2;
  localparam int RK_WHITE_C = 2 * ROUNDS + 3;

  localparam int KEY_ROT  = 3;
  localparam int QUAD_ROT = 5;

  typedef enum logic {
    REQ_ENCRYPT = 1'b0,
    REQ_DECRYPT = 1'b1
  } req_type_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_KEY_01    = 3'd0,
    REG_KEY_23    = 3'd1,
    REG_KEY_45    = 3'd2,
    REG_KEY_67    = 3'd3,
    REG_KEY_COUNT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic  en;
    word_t x;
  } quad_req_t;

  function automatic word_t rotl(word_t x, logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] d;
    d = {x, x} << n;
    return d[2*WORD_W-1:WORD_W];
  endfunction

  function automatic word_t rotr(word_t x, logic [ROT_W-1:0] n);
    logic [2*WORD_W-1:0] d;
    d = {x, x} >> n;
    return d[WORD_W-1:0];
  endfunction

endpackage

// ----- rtl/core/rc6_quad_mix.sv -----
// Registered quadratic mixing unit: rotl(x * (2x + 1), 5) modulo 2^32.
module rc6_quad_mix (
  input  logic              clk,
  input  rc6_pkg::quad_req_t req,
  output rc6_pkg::word_t     q
);
  import rc6_pkg::*;

  word_t odd;
  word_t prod;
  word_t q_r;

  assign odd  = {req.x[WORD_W-2:0], 1'b1};
  assign prod = req.x * odd;

  always_ff @(posedge clk) begin
    if (req.en) begin
      q_r <= rotl(prod, ROT_W'(QUAD_ROT));
    end
  end

  assign q = q_r;

endmodule

// ----- rtl/core/rc6_block_cipher.sv -----
// Top level of the RC6-32/20 block cipher with on-chip key expansion.
//
// The block encrypts or decrypts one 128-bit block per request, given as the
// four words A, B, C and D, and returns one result of four words. The key lives
// in the APB registers: four 64-bit registers hold key words 0 to 7 (the even
// word in the low half) and a count register selects how many words are used;
// a count of zero is treated as one and a count above eight as eight. Any write
// to a known register marks the round-key table stale, and the next request
// first expands the key: the table is filled from the magic constants, then
// 132 mixing steps, each split into a round-key update and a scratch-word
// update, run through the one round-key RAM. After that a request runs through
// input whitening, the 20 rounds, output whitening, the hand-off of the result
// to the output register and an idle state in which the next request is taken;
// the hand-off waits while a previous result is still held in the output
// register under a stall. A round is split into phases because of the one
// 32x32 multiplier, which is used twice per round, and the registered read of
// the round-key RAM. in_stall is low only while the block is idle, and a
// finished result waits in the output register so that the next request can
// be accepted before the previous result is taken. Registers may be written
// only while no request is in progress.
module rc6_block_cipher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rc6_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [rc6_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rc6_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_req_type,
  input  rc6_pkg::word_t                     in_a,
  input  rc6_pkg::word_t                     in_b,
  input  rc6_pkg::word_t                     in_c,
  input  rc6_pkg::word_t                     in_d,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rc6_pkg::word_t                     out_a,
  output rc6_pkg::word_t                     out_b,
  output rc6_pkg::word_t                     out_c,
  output rc6_pkg::word_t                     out_d
);
  import rc6_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_MIX_X,
    ST_MIX_Y,
    ST_PRE0,
    ST_PRE1,
    ST_PRE2,
    ST_RND,
    ST_POST0,
    ST_POST1,
    ST_POST2,
    ST_FIN
  } state_t;

  // Control state.
  state_t                  state_r, state_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    sched_done_r, sched_done_nxt;
  logic [ROUND_W-1:0]      rnd_r, rnd_nxt;
  logic [1:0]              phase_r, phase_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [ADDR_W-1:0]       mix_i_r, mix_i_nxt;
  logic [KIDX_W-1:0]       mix_j_r, mix_j_nxt;
  logic [CFG_DATA_W-1:0]   key_regs_r [KEY_REGS];
  logic [CFG_DATA_W-1:0]   key_regs_nxt [KEY_REGS];
  logic [KCNT_W-1:0]       key_cnt_r, key_cnt_nxt;

  // Datapath registers.
  req_type_t               req_r, req_nxt;
  word_t                   wa_r, wa_nxt, wb_r, wb_nxt, wc_r, wc_nxt, wd_r, wd_nxt;
  word_t                   t_r, t_nxt, u_r, u_nxt, tmp_r, tmp_nxt;
  word_t                   mix_a_r, mix_a_nxt, mix_b_r, mix_b_nxt;
  word_t                   fill_val_r, fill_val_nxt;
  word_t                   out_a_r, out_b_r, out_c_r, out_d_r;
  logic                    out_load;

  // Round-key RAM and key scratch words.
  word_t                   rk_mem [TABLE_SIZE];
  word_t                   rk_rdata_r;
  logic                    rk_we;
  logic [ADDR_W-1:0]       rk_waddr, rk_raddr;
  word_t                   rk_wdata;
  word_t                   scratch_r [MAX_KEY_WORDS];
  logic                    scr_load, scr_we;

  // Shared multiplier.
  quad_req_t               quad_req;
  word_t                   quad_q;

  // Configuration decode.
  logic                    cfg_we;
  cfg_reg_t                cfg_idx;
  logic [KCNT_W-1:0]       c_eff;
  logic [STEP_W-1:0]       step_last;
  logic                    in_acc;
  logic                    is_dec;

  // Mixing arithmetic.
  word_t                   mix_a_new, mix_ab, mix_b_new;
  logic [ADDR_W-1:0]       mix_i_wrap;
  logic [KIDX_W-1:0]       mix_j_wrap;

  rc6_quad_mix u_quad (
    .clk (clk),
    .req (quad_req),
    .q   (quad_q)
  );

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W]);

  always_comb begin
    case (cfg_idx)
      REG_KEY_01:    prdata = key_regs_r[0];
      REG_KEY_23:    prdata = key_regs_r[1];
      REG_KEY_45:    prdata = key_regs_r[2];
      REG_KEY_67:    prdata = key_regs_r[3];
      REG_KEY_COUNT: prdata = CFG_DATA_W'(key_cnt_r);
      default:       prdata = '0;
    endcase
  end

  // The count register is saturated into the range the schedule supports.
  always_comb begin
    if (key_cnt_r == '0) begin
      c_eff = KCNT_W'(1);
    end else if (32'(key_cnt_r) > KEY_CAP) begin
      c_eff = KCNT_W'(KEY_CAP);
    end else begin
      c_eff = key_cnt_r;
    end
  end

  assign step_last = (32'(c_eff) > TABLE_SIZE) ? STEP_W'(3 * 32'(c_eff) - 1)
                                               : STEP_W'(3 * TABLE_SIZE - 1);

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign is_dec   = (req_r == REQ_DECRYPT);

  // One key-mixing step is split over ST_MIX_X and ST_MIX_Y: the round-key update,
  // then the scratch-word update with its data-dependent rotation.
  assign mix_a_new  = rotl(rk_rdata_r + mix_a_r + mix_b_r, ROT_W'(KEY_ROT));
  assign mix_ab     = mix_a_r + mix_b_r;
  assign mix_b_new  = rotl(scratch_r[mix_j_r] + mix_ab, mix_ab[ROT_W-1:0]);
  assign mix_i_wrap = (mix_i_r == ADDR_W'(TABLE_SIZE - 1)) ? '0 : mix_i_r + 1'b1;
  assign mix_j_wrap = (KCNT_W'(mix_j_r) == c_eff - KCNT_W'(1)) ? '0 : mix_j_r + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    sched_done_nxt = sched_done_r;
    rnd_nxt        = rnd_r;
    phase_nxt      = phase_r;
    step_nxt       = step_r;
    mix_i_nxt      = mix_i_r;
    mix_j_nxt      = mix_j_r;
    key_regs_nxt   = key_regs_r;
    key_cnt_nxt    = key_cnt_r;
    req_nxt        = req_r;
    wa_nxt         = wa_r;
    wb_nxt         = wb_r;
    wc_nxt         = wc_r;
    wd_nxt         = wd_r;
    t_nxt          = t_r;
    u_nxt          = u_r;
    tmp_nxt        = tmp_r;
    mix_a_nxt      = mix_a_r;
    mix_b_nxt      = mix_b_r;
    fill_val_nxt   = fill_val_r;
    out_load       = 1'b0;
    rk_we          = 1'b0;
    rk_waddr       = mix_i_r;
    rk_wdata       = fill_val_r;
    rk_raddr       = '0;
    scr_load       = 1'b0;
    scr_we         = 1'b0;
    quad_req.en    = 1'b0;
    quad_req.x     = wb_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // A write to a known register updates it and marks the schedule stale.
    if (cfg_we) begin
      case (cfg_idx)
        REG_KEY_01: begin
          key_regs_nxt[0] = pwdata;
          sched_done_nxt  = 1'b0;
        end
        REG_KEY_23: begin
          key_regs_nxt[1] = pwdata;
          sched_done_nxt  = 1'b0;
        end
        REG_KEY_45: begin
          key_regs_nxt[2] = pwdata;
          sched_done_nxt  = 1'b0;
        end
        REG_KEY_67: begin
          key_regs_nxt[3] = pwdata;
          sched_done_nxt  = 1'b0;
        end
        REG_KEY_COUNT: begin
          key_cnt_nxt    = pwdata[KCNT_W-1:0];
          sched_done_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt = req_type_t'(in_req_type);
          wa_nxt  = in_a;
          wb_nxt  = in_b;
          wc_nxt  = in_c;
          wd_nxt  = in_d;
          if (sched_done_r) begin
            state_nxt = ST_PRE0;
          end else begin
            scr_load     = 1'b1;
            mix_i_nxt    = '0;
            fill_val_nxt = MAGIC_P;
            state_nxt    = ST_FILL;
          end
        end
      end

      ST_FILL: begin
        rk_we        = 1'b1;
        fill_val_nxt = fill_val_r + MAGIC_Q;
        if (mix_i_r == ADDR_W'(TABLE_SIZE - 1)) begin
          mix_i_nxt = '0;
          mix_j_nxt = '0;
          step_nxt  = '0;
          mix_a_nxt = '0;
          mix_b_nxt = '0;
          state_nxt = ST_MIX_X;
        end else begin
          mix_i_nxt = mix_i_r + 1'b1;
        end
      end

      ST_MIX_X: begin
        rk_we     = 1'b1;
        rk_wdata  = mix_a_new;
        mix_a_nxt = mix_a_new;
        state_nxt = ST_MIX_Y;
      end

      ST_MIX_Y: begin
        scr_we    = 1'b1;
        mix_b_nxt = mix_b_new;
        mix_i_nxt = mix_i_wrap;
        mix_j_nxt = mix_j_wrap;
        rk_raddr  = mix_i_wrap;
        step_nxt  = step_r + 1'b1;
        if (step_r == step_last) begin
          sched_done_nxt = 1'b1;
          state_nxt      = ST_PRE0;
        end else begin
          state_nxt = ST_MIX_X;
        end
      end

      ST_PRE0: begin
        rk_raddr  = is_dec ? ADDR_W'(RK_WHITE_C) : ADDR_W'(RK_WHITE_B);
        state_nxt = ST_PRE1;
      end

      ST_PRE1: begin
        if (is_dec) begin
          wc_nxt = wc_r - rk_rdata_r;
        end else begin
          wb_nxt = wb_r + rk_rdata_r;
        end
        rk_raddr  = is_dec ? ADDR_W'(RK_WHITE_A) : ADDR_W'(RK_WHITE_D);
        state_nxt = ST_PRE2;
      end

      ST_PRE2: begin
        if (is_dec) begin
          wa_nxt  = wa_r - rk_rdata_r;
          rnd_nxt = ROUND_W'(ROUNDS);
        end else begin
          wd_nxt  = wd_r + rk_rdata_r;
          rnd_nxt = ROUND_W'(1);
        end
        phase_nxt = '0;
        state_nxt = ST_RND;
      end

      ST_RND: begin
        phase_nxt = phase_r + 1'b1;
        case (phase_r)
          2'd0: begin
            quad_req.en = 1'b1;
            quad_req.x  = is_dec ? wa_r : wb_r;
          end
          2'd1: begin
            t_nxt       = quad_q;
            quad_req.en = 1'b1;
            quad_req.x  = is_dec ? wc_r : wd_r;
            rk_raddr    = ADDR_W'({rnd_r, 1'b0});
          end
          2'd2: begin
            u_nxt    = quad_q;
            rk_raddr = ADDR_W'({rnd_r, 1'b1});
            if (is_dec) begin
              tmp_nxt = rotr(wd_r - rk_rdata_r, quad_q[ROT_W-1:0]) ^ t_r;
            end else begin
              tmp_nxt = rotl(wa_r ^ t_r, quad_q[ROT_W-1:0]) + rk_rdata_r;
            end
          end
          default: begin
            // Last phase: finish word C and rotate the four words.
            if (is_dec) begin
              wa_nxt = tmp_r;
              wb_nxt = wa_r;
              wc_nxt = rotr(wb_r - rk_rdata_r, t_r[ROT_W-1:0]) ^ u_r;
              wd_nxt = wc_r;
              if (rnd_r == ROUND_W'(1)) begin
                state_nxt = ST_POST0;
              end else begin
                rnd_nxt = rnd_r - 1'b1;
              end
            end else begin
              wa_nxt = wb_r;
              wb_nxt = rotl(wc_r ^ u_r, t_r[ROT_W-1:0]) + rk_rdata_r;
              wc_nxt = wd_r;
              wd_nxt = tmp_r;
              if (rnd_r == ROUND_W'(ROUNDS)) begin
                state_nxt = ST_POST0;
              end else begin
                rnd_nxt = rnd_r + 1'b1;
              end
            end
          end
        endcase
      end

      ST_POST0: begin
        rk_raddr  = is_dec ? ADDR_W'(RK_WHITE_D) : ADDR_W'(RK_WHITE_A);
        state_nxt = ST_POST1;
      end

      ST_POST1: begin
        if (is_dec) begin
          wd_nxt = wd_r - rk_rdata_r;
        end else begin
          wa_nxt = wa_r + rk_rdata_r;
        end
        rk_raddr  = is_dec ? ADDR_W'(RK_WHITE_B) : ADDR_W'(RK_WHITE_C);
        state_nxt = ST_POST2;
      end

      ST_POST2: begin
        if (is_dec) begin
          wb_nxt = wb_r - rk_rdata_r;
        end else begin
          wc_nxt = wc_r + rk_rdata_r;
        end
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // The result moves out once the output register is free or emptying.
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      sched_done_r <= 1'b0;
      rnd_r        <= '0;
      phase_r      <= '0;
      step_r       <= '0;
      mix_i_r      <= '0;
      mix_j_r      <= '0;
      for (int k = 0; k < KEY_REGS; k++) begin
        key_regs_r[k] <= '0;
      end
      key_cnt_r    <= KCNT_W'(4);
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      sched_done_r <= sched_done_nxt;
      rnd_r        <= rnd_nxt;
      phase_r      <= phase_nxt;
      step_r       <= step_nxt;
      mix_i_r      <= mix_i_nxt;
      mix_j_r      <= mix_j_nxt;
      key_regs_r   <= key_regs_nxt;
      key_cnt_r    <= key_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    wa_r       <= wa_nxt;
    wb_r       <= wb_nxt;
    wc_r       <= wc_nxt;
    wd_r       <= wd_nxt;
    t_r        <= t_nxt;
    u_r        <= u_nxt;
    tmp_r      <= tmp_nxt;
    mix_a_r    <= mix_a_nxt;
    mix_b_r    <= mix_b_nxt;
    fill_val_r <= fill_val_nxt;
    if (out_load) begin
      out_a_r <= wa_r;
      out_b_r <= wb_r;
      out_c_r <= wc_r;
      out_d_r <= wd_r;
    end
  end

  // Round-key RAM: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (rk_we) begin
      rk_mem[rk_waddr] <= rk_wdata;
    end
    rk_rdata_r <= rk_mem[rk_raddr];
  end

  // Key scratch words: loaded from the registers, then rewritten by mixing.
  // Words beyond the registers start out as zero.
  always_ff @(posedge clk) begin
    if (scr_load) begin
      for (int n = 0; n < MAX_KEY_WORDS; n++) begin
        if (n < KEY_REG_WORDS) begin
          scratch_r[n] <= key_regs_r[n >> 1][(n & 1) * WORD_W +: WORD_W];
        end else begin
          scratch_r[n] <= '0;
        end
      end
    end else if (scr_we) begin
      scratch_r[mix_j_r] <= mix_b_new;
    end
  end

  assign out_valid = out_valid_r;
  assign out_a     = out_a_r;
  assign out_b     = out_b_r;
  assign out_c     = out_c_r;
  assign out_d     = out_d_r;

  // A result appears only when the sequencer hands it over.
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FIN))
    else $error("result raised outside the hand-off state");

  // A request against a stale key table must start the expansion.
  a_stale_expands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !sched_done_r) |=> (state_r == ST_FILL))
    else $error("stale key table not expanded");

  // The round counter stays within the round range while rounds run.
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RND) |-> (rnd_r != '0 && rnd_r <= ROUND_W'(ROUNDS)))
    else $error("round counter out of range");

  // The scratch index never passes the key word count during mixing.
  a_scratch_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIX_X || state_r == ST_MIX_Y) |-> (KCNT_W'(mix_j_r) < c_eff))
    else $error("scratch index beyond key word count");

endmodule

// ----- bench/rc6_block_checker.sv -----
// Scoreboard for the RC6 block cipher: mirrors the key registers, predicts each block, checks it.
module rc6_block_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rc6_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rc6_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_req_type,
  input  rc6_pkg::word_t                 in_a,
  input  rc6_pkg::word_t                 in_b,
  input  rc6_pkg::word_t                 in_c,
  input  rc6_pkg::word_t                 in_d,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  rc6_pkg::word_t                 out_a,
  input  rc6_pkg::word_t                 out_b,
  input  rc6_pkg::word_t                 out_c,
  input  rc6_pkg::word_t                 out_d,
  output int                             errors,
  output int                             outstanding
);
  import rc6_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } block_t;

  logic [CFG_DATA_W-1:0] key_reg [KEY_REGS];
  logic [KCNT_W-1:0]     key_count;
  word_t                 round_key [TABLE_SIZE];
  bit                    keys_fresh;
  block_t                expected_blocks [$];
  int                    fail_cnt = 0;
  logic [REG_IDX_W-1:0]  reg_idx;
  block_t                predicted;
  block_t                want;
  block_t                got;

  function automatic word_t rol32(word_t x, word_t n);
    int unsigned s;
    s = n % 32;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic word_t ror32(word_t x, word_t n);
    int unsigned s;
    s = n % 32;
    if (s == 0) return x;
    return (x >> s) | (x << (32 - s));
  endfunction

  // f(x) = x * (2x + 1) mod 2^32, rotated left by five.
  function automatic word_t quad_spread(word_t x);
    word_t p;
    p = x * ((x << 1) + 32'd1);
    return rol32(p, QUAD_ROT);
  endfunction

  function automatic void expand_round_keys();
    int unsigned words;
    int unsigned steps;
    int unsigned i;
    int unsigned j;
    word_t       x;
    word_t       y;
    word_t       scratch [MAX_KEY_WORDS];
    words = key_count;
    if (words < 1) words = 1;
    if (words > MAX_KEY_WORDS) words = MAX_KEY_WORDS;
    round_key[0] = MAGIC_P;
    for (int n = 1; n < TABLE_SIZE; n++) round_key[n] = round_key[n-1] + MAGIC_Q;
    for (int n = 0; n < words; n++)
      scratch[n] = (n < 2 * KEY_REGS) ? key_reg[n / 2][32 * (n % 2) +: 32] : '0;
    steps = 3 * ((words > TABLE_SIZE) ? words : TABLE_SIZE);
    x = '0;
    y = '0;
    i = 0;
    j = 0;
    repeat (steps) begin
      x = rol32(round_key[i] + x + y, KEY_ROT);
      round_key[i] = x;
      y = rol32(scratch[j] + x + y, x + y);
      scratch[j] = y;
      i = (i + 1) % TABLE_SIZE;
      j = (j + 1) % words;
    end
    keys_fresh = 1'b1;
  endfunction

  function automatic block_t rc6_transform(req_type_t op, block_t v);
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t t;
    word_t u;
    word_t hold;
    a = v.a;
    b = v.b;
    c = v.c;
    d = v.d;
    if (op == REQ_ENCRYPT) begin
      b += round_key[RK_WHITE_B];
      d += round_key[RK_WHITE_D];
      for (int r = 1; r <= ROUNDS; r++) begin
        t = quad_spread(b);
        u = quad_spread(d);
        a = rol32(a ^ t, u) + round_key[2*r];
        c = rol32(c ^ u, t) + round_key[2*r+1];
        hold = a; a = b; b = c; c = d; d = hold;
      end
      a += round_key[RK_WHITE_A];
      c += round_key[RK_WHITE_C];
    end else begin
      c -= round_key[RK_WHITE_C];
      a -= round_key[RK_WHITE_A];
      for (int r = ROUNDS; r > 0; r--) begin
        hold = d; d = c; c = b; b = a; a = hold;
        u = quad_spread(d);
        t = quad_spread(b);
        c = ror32(c - round_key[2*r+1], t) ^ u;
        a = ror32(a - round_key[2*r], u) ^ t;
      end
      d -= round_key[RK_WHITE_D];
      b -= round_key[RK_WHITE_B];
    end
    return '{a, b, c, d};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (key_reg[k]) key_reg[k] = '0;
      key_count  = KCNT_W'(4);
      keys_fresh = 1'b0;
      expected_blocks.delete();
    end else begin
      // Writes to addresses past the count register are ignored.
      if (psel && penable && pwrite && pready) begin
        reg_idx = paddr[CFG_ADDR_W-1 -: REG_IDX_W];
        if (reg_idx <= REG_KEY_67) begin
          key_reg[reg_idx] = pwdata;
          keys_fresh = 1'b0;
        end else if (reg_idx == REG_KEY_COUNT) begin
          key_count  = pwdata[KCNT_W-1:0];
          keys_fresh = 1'b0;
        end
      end
      if (in_valid && !in_stall) begin
        if (!keys_fresh) expand_round_keys();
        predicted = rc6_transform(req_type_t'(in_req_type), '{in_a, in_b, in_c, in_d});
        expected_blocks.insert(expected_blocks.size(), predicted);
      end
      if (out_valid && !out_stall) begin
        got = '{out_a, out_b, out_c, out_d};
        if (expected_blocks.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_LIMIT)
            $display("%0t: result with no request pending: %h %h %h %h",
                     $realtime, got.a, got.b, got.c, got.d);
        end else begin
          want = expected_blocks.pop_front();
          if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
              got.d !== want.d) begin
            fail_cnt++;
            if (fail_cnt <= REPORT_LIMIT)
              $display("%0t: block mismatch, expected %h %h %h %h, got %h %h %h %h",
                       $realtime, want.a, want.b, want.c, want.d,
                       got.a, got.b, got.c, got.d);
          end
        end
      end
    end
    outstanding <= expected_blocks.size();
    errors      <= fail_cnt;
  end

endmodule

// ----- bench/tb_rc6_block_cipher.sv -----
// Testbench top for the RC6 block cipher: makes requests, key writes and result stalls.
module tb_rc6_block_cipher;
  import rc6_pkg::*;

  // Random traffic comes in phases; each phase starts from an idle block and may rewrite the key.
  localparam int RANDOM_PHASES    = 8;
  localparam int BLOCKS_PER_PHASE = 235;
  localparam int MAX_BURST        = 12;
  localparam int MAX_GAP          = 120;
  localparam int MAX_SINK_SPAN    = 40;
  localparam int DEEP_HOLD_CYCLES = 700;
  // Long enough for the last request to run through the block.
  localparam int TAIL_CYCLES      = 100;
  // Sized for about 1900 requests, each with its schedule, the longest gap and the longest
  // sink span, plus key expansions and the long hold-off, with a margin of four times.
  localparam int TIME_LIMIT       = 8_000_000;

  // Register slots past the count register decode to nothing.
  localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = REG_IDX_W'(REG_KEY_COUNT + 1);
  localparam logic [REG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  typedef enum int {
    SINK_OPEN,
    SINK_RANDOM,
    SINK_TOGGLE,
    SINK_BLOCKED
  } sink_mode_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr       = '0;
  logic [CFG_DATA_W-1:0] pwdata      = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  in_req_type = 1'b0;
  word_t                 in_a        = '0;
  word_t                 in_b        = '0;
  word_t                 in_c        = '0;
  word_t                 in_d        = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  word_t                 out_a;
  word_t                 out_b;
  word_t                 out_c;
  word_t                 out_d;
  int                    mismatches;
  int                    outstanding;
  // Raised once by the stimulus to ask the result side for its long hold-off.
  logic                  deep_hold_req = 1'b0;

  rc6_block_cipher uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_a        (in_a),
    .in_b        (in_b),
    .in_c        (in_c),
    .in_d        (in_d),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_a       (out_a),
    .out_b       (out_b),
    .out_c       (out_c),
    .out_d       (out_d)
  );

  // The scoreboard watches the same wires as the block and reports back a count of
  // failed checks and the number of requests whose results are still due.
  rc6_block_checker block_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_a        (in_a),
    .in_b        (in_b),
    .in_c        (in_c),
    .in_d        (in_d),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_a       (out_a),
    .out_b       (out_b),
    .out_c       (out_c),
    .out_d       (out_d),
    .errors      (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // One APB write: the setup phase, then the access phase, which completes at the
  // first edge with pready high. The bus then idles before the task returns, so that a following
  // write never raises psel in the same step that this one lowers it.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(8 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one request and returns in the step in which it was taken. Valid stays
  // high on return; the caller lowers it only when a gap follows.
  task automatic send_block(input req_type_t op, input word_t a, input word_t b,
                            input word_t c, input word_t d);
    in_valid    <= 1'b1;
    in_req_type <= op;
    in_a        <= a;
    in_b        <= b;
    in_c        <= c;
    in_d        <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every request has produced its result. The first
  // edge is skipped because the scoreboard count is registered and lags the acceptance.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Data words lean toward the corners: zero, all ones, one hot and one cold.
  function automatic word_t pick_word();
    int unsigned k;
    k = $urandom_range(0, 31);
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return word_t'(1) << k;
      3: return ~(word_t'(1) << k);
      default: return $urandom;
    endcase
  endfunction

  // Rewrites a random subset of the key registers. The count is mostly legal, but a
  // zero or a value above eight shows up too, and now and then a spare slot is hit.
  task automatic retune_key();
    for (int r = 0; r < KEY_REGS; r++)
      if ($urandom_range(0, 1))
        write_reg(REG_IDX_W'(REG_KEY_01 + r), {pick_word(), pick_word()});
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 2) != 0)
        write_reg(REG_KEY_COUNT, CFG_DATA_W'($urandom_range(1, MAX_KEY_WORDS)));
      else
        write_reg(REG_KEY_COUNT, CFG_DATA_W'($urandom_range(0, 15)));
    end
    if ($urandom_range(0, 5) == 0)
      write_reg(REG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                {$urandom, $urandom});
  endtask

  // Bursts of back-to-back requests separated by random gaps. The gaps shift where
  // the next request lands within the block's schedule; once in a while the
  // sender waits for the block to empty completely.
  task automatic run_traffic(input int count);
    int burst;
    int left;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, MAX_BURST);
      if (burst > left) burst = left;
      repeat (burst)
        send_block(req_type_t'($urandom_range(0, 1)),
                   pick_word(), pick_word(), pick_word(), pick_word());
      left -= burst;
      case ($urandom_range(0, 19))
        0: drain();
        1, 2, 3, 4: ;
        default: pause($urandom_range(1, MAX_GAP));
      endcase
    end
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The key from reset (all zero words, four in use), with the corner values of
    // every data word in both directions, offered back to back.
    send_block(REQ_ENCRYPT, '0, '0, '0, '0);
    send_block(REQ_ENCRYPT, '1, '1, '1, '1);
    send_block(REQ_DECRYPT, '0, '0, '0, '0);
    send_block(REQ_DECRYPT, '1, '1, '1, '1);
    send_block(REQ_ENCRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_block(REQ_DECRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_block(REQ_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    send_block(REQ_DECRYPT, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFE);
    drain();

    // All eight key words set to ones, the largest legal count.
    write_reg(REG_KEY_01, '1);
    write_reg(REG_KEY_23, '1);
    write_reg(REG_KEY_45, '1);
    write_reg(REG_KEY_67, '1);
    write_reg(REG_KEY_COUNT, CFG_DATA_W'(MAX_KEY_WORDS));
    send_block(REQ_ENCRYPT, '0, '0, '0, '0);
    send_block(REQ_DECRYPT, '1, '1, '1, '1);
    send_block(REQ_ENCRYPT, pick_word(), pick_word(), pick_word(), pick_word());
    drain();

    // A count of zero must behave as a single key word.
    write_reg(REG_KEY_01, 64'h0123_4567_89AB_CDEF);
    write_reg(REG_KEY_COUNT, '0);
    send_block(REQ_ENCRYPT, '0, '1, '0, '1);
    send_block(REQ_DECRYPT, '1, '0, '1, '0);
    send_block(REQ_ENCRYPT, pick_word(), pick_word(), pick_word(), pick_word());
    drain();

    // The largest count value saturates at eight words; writes to the spare slots
    // must leave the key alone.
    write_reg(REG_KEY_23, {$urandom, $urandom});
    write_reg(REG_KEY_45, {$urandom, $urandom});
    write_reg(REG_KEY_67, {$urandom, $urandom});
    write_reg(REG_KEY_COUNT, CFG_DATA_W'(15));
    write_reg(REG_SPARE_FIRST, {$urandom, $urandom});
    write_reg(REG_SPARE_LAST, '1);
    send_block(REQ_ENCRYPT, pick_word(), pick_word(), pick_word(), pick_word());
    send_block(REQ_DECRYPT, pick_word(), pick_word(), pick_word(), pick_word());
    send_block(REQ_ENCRYPT, pick_word(), pick_word(), pick_word(), pick_word());
    drain();

    // Just above the limit, with a cleared first pair of words.
    write_reg(REG_KEY_01, '0);
    write_reg(REG_KEY_COUNT, CFG_DATA_W'(MAX_KEY_WORDS + 1));
    send_block(REQ_DECRYPT, pick_word(), pick_word(), pick_word(), pick_word());
    send_block(REQ_ENCRYPT, pick_word(), pick_word(), pick_word(), pick_word());
    drain();

    // Random phases. The first one also triggers the long hold-off on the result side
    // while requests keep coming, so the block fills and stalls its input.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      retune_key();
      if (phase == 0) deep_hold_req <= 1'b1;
      run_traffic(BLOCKS_PER_PHASE);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    // Any result still owed at this point is a failure as well.
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Result side: stretches of random length, each with its own stall pattern. The
  // long hold-off is counted here, independent of the request side.
  initial begin : result_sink
    sink_mode_t mode;
    int         span;
    bit         deep_done;
    deep_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (deep_hold_req && !deep_done) begin
        deep_done = 1'b1;
        out_stall <= 1'b1;
        repeat (DEEP_HOLD_CYCLES) @(posedge clk);
      end
      mode = sink_mode_t'($urandom_range(SINK_OPEN, SINK_BLOCKED));
      span = $urandom_range(1, MAX_SINK_SPAN);
      repeat (span) begin
        case (mode)
          SINK_OPEN:    out_stall <= 1'b0;
          SINK_RANDOM:  out_stall <= 1'($urandom_range(0, 1));
          SINK_TOGGLE:  out_stall <= ~out_stall;
          SINK_BLOCKED: out_stall <= 1'b1;
          default:      out_stall <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(TIME_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- rc6_block_cipher.f -----
rtl/core/rc6_pkg.sv
rtl/core/rc6_quad_mix.sv
rtl/core/rc6_block_cipher.sv
bench/rc6_block_checker.sv
bench/tb_rc6_block_cipher.sv
